// ===== sv/polygon_stream_fan_decoder_core_assert.svh =====
// Assertion macros for the polygon stream fan decoder checker.
// Included by the checker file only; no other dependencies.
`ifndef POLYGON_STREAM_FAN_DECODER_CORE_ASSERT_SVH
`define POLYGON_STREAM_FAN_DECODER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PSFD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define PSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/psfd_pkg.sv =====
// Shared types and constants for the polygon stream fan decoder.
// No dependencies.
package psfd_pkg;

    localparam int VertexSlots  = 256;
    localparam int MaxPolyVerts = 15;
    localparam int BlockBits    = 16;
    localparam int PaletteSize  = 16;

    localparam int SlotW = $clog2(VertexSlots);
    localparam int PvW   = $clog2(MaxPolyVerts);

    localparam logic [1:0] KIND_TRI    = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_STREAM = 2'd2;

    localparam logic [7:0] CODE_END    = 8'hff;
    localparam logic [7:0] CODE_SKIP   = 8'hfe;
    localparam logic [7:0] CODE_STREAM = 8'hfd;

    typedef enum logic [3:0] {
        PH_FLAGS, PH_MASK_HI, PH_MASK_LO, PH_PAL_HI, PH_PAL_LO, PH_VCOUNT,
        PH_VX, PH_VY, PH_POLY, PH_PIDX, PH_PX, PH_PY, PH_SKIP
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       emit_marker; // load a frame or stream end result
        logic [1:0] marker_kind;
        logic       emit_clear;  // load a clear triangle
        logic       clear_second;
        logic       emit_fan;    // load fan triangle fan_index
        logic [PvW-1:0] fan_index;
        logic       mark_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] ax, ay, bx, by, cx, cy;
        logic [7:0] color;
        logic       last;
    } result_t;

    function automatic logic [7:0] pack_rgb(input logic [15:0] rgb);
        pack_rgb = {rgb[1:0], rgb[6:4], rgb[10:8]};
    endfunction

endpackage

// ===== sv/psfd_datapath.sv =====
// Datapath: polygon vertex buffer and the output result register.
// Depends on psfd_pkg.
module psfd_datapath
    import psfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic [PvW-1:0]   vert_wr_idx,
    input  logic             vert_we,
    input  logic [7:0]       vert_x,
    input  logic [7:0]       vert_y,
    input  logic [7:0]       fan_color,
    output dp_stat_t         stat,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_res
);
    logic [7:0] px_reg [MaxPolyVerts];
    logic [7:0] py_reg [MaxPolyVerts];
    logic       valid_reg, valid_next;
    result_t    res_reg, res_next;
    logic       load;
    logic [PvW-1:0] ib, ic;

    always_ff @(posedge clk)
    begin
        if (vert_we)
        begin
            px_reg[vert_wr_idx] <= vert_x;
            py_reg[vert_wr_idx] <= vert_y;
        end
    end

    assign load = cmd.emit_marker | cmd.emit_clear | cmd.emit_fan;
    assign ib = cmd.fan_index + PvW'(2);
    assign ic = cmd.fan_index + PvW'(1);

    always_comb
    begin
        res_next = res_reg;
        valid_next = valid_reg & ~out_ready;
        if (load)
        begin
            valid_next = 1'b1;
            res_next = '0;
            res_next.last = cmd.mark_last;
            if (cmd.emit_marker)
            begin
                res_next.kind = cmd.marker_kind;
            end
            else if (cmd.emit_clear)
            begin
                res_next.kind = KIND_TRI;
                if (!cmd.clear_second)
                begin
                    res_next.by = 9'd200; res_next.cx = 9'd256; res_next.cy = 9'd200;
                end
                else
                begin
                    res_next.ax = 9'd256; res_next.ay = 9'd200; res_next.bx = 9'd256;
                end
            end
            else
            begin
                res_next.kind  = KIND_TRI;
                res_next.ax    = {1'b0, px_reg[0]};
                res_next.ay    = {1'b0, py_reg[0]};
                res_next.bx    = {1'b0, px_reg[ib]};
                res_next.by    = {1'b0, py_reg[ib]};
                res_next.cx    = {1'b0, px_reg[ic]};
                res_next.cy    = {1'b0, py_reg[ic]};
                res_next.color = fan_color;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign stat.out_busy = valid_reg & ~out_ready;
    assign out_valid = valid_reg;
    assign out_res = res_reg;
endmodule

// ===== sv/psfd_ctrl.sv =====
// Controller: stream parser state machine, palette, vertex table and fan sequencing.
// Depends on psfd_pkg.
module psfd_ctrl
    import psfd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  dp_stat_t       stat,
    output dp_cmd_t        cmd,
    output logic [PvW-1:0] vert_wr_idx,
    output logic           vert_we,
    output logic [7:0]     vert_x,
    output logic [7:0]     vert_y,
    output logic [7:0]     fan_color
);
    typedef enum logic [1:0] { S_IN, S_FETCH, S_CLEAR2, S_FAN } seq_t;

    logic [7:0] vxs_mem [VertexSlots];
    logic [7:0] vys_mem [VertexSlots];
    logic [7:0] rdx_reg, rdy_reg;

    seq_t    seq_reg, seq_next;
    phase_t  ph_reg, ph_next;
    logic [2:0]  flags_reg, flags_next;
    logic [15:0] mask_reg, mask_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  cmap_reg [PaletteSize];
    logic [7:0]  vtot_reg, vtot_next;
    logic [7:0]  vcnt_reg, vcnt_next;
    logic [3:0]  pcnt_reg, pcnt_next;
    logic [3:0]  pcol_reg, pcol_next;
    logic [7:0]  pend_reg, pend_next;
    logic [BlockBits-1:0] pos_reg, pos_next;
    logic [PvW-1:0] fan_reg, fan_next, fan_last_reg, fan_last_next;

    logic        take, can_issue;
    logic        cmap_we;
    logic [3:0]  cmap_idx;
    logic [3:0]  top_bit;
    logic        tbl_we;
    logic [SlotW-1:0] tbl_idx;
    logic        fetch_req;
    logic [3:0]  fan_cnt;
    logic        vert_take;
    logic [7:0]  vx_in, vy_in;
    logic        start_clear;

    assign can_issue = ~stat.out_busy;
    assign in_ready  = (seq_reg == S_IN) & can_issue;
    assign take      = in_valid & in_ready;

    // Highest set bit of the stored palette mask; the next palette word loads entry 15 minus this bit.
    always_comb
    begin
        top_bit = 4'd0;
        for (int b = 0; b < 16; b++)
        begin
            if (mask_reg[b])
            begin
                top_bit = 4'(b);
            end
        end
    end

    always_comb
    begin
        seq_next = seq_reg;   ph_next = ph_reg;     flags_next = flags_reg;
        mask_next = mask_reg; hi_next = hi_reg;     vtot_next = vtot_reg;
        vcnt_next = vcnt_reg; pcnt_next = pcnt_reg; pcol_next = pcol_reg;
        pend_next = pend_reg; pos_next = pos_reg;   fan_next = fan_reg;
        fan_last_next = fan_last_reg;
        cmd = '0;
        cmap_we = 1'b0; cmap_idx = '0;
        tbl_we = 1'b0; tbl_idx = SlotW'(vcnt_reg);
        fetch_req = 1'b0;
        vert_take = 1'b0; vx_in = pend_reg; vy_in = in_byte;
        start_clear = 1'b0;
        fan_cnt = (pcnt_reg > 4'(MaxPolyVerts)) ? 4'(MaxPolyVerts) : pcnt_reg;

        case (seq_reg)
            S_IN:
            begin
                if (take)
                begin
                    pos_next = pos_reg + BlockBits'(1);
                    case (ph_reg)
                        PH_MASK_HI:
                        begin
                            hi_next = in_byte; ph_next = PH_MASK_LO;
                        end
                        PH_MASK_LO:
                        begin
                            mask_next = {hi_reg, in_byte};
                            if (mask_next != 16'd0) ph_next = PH_PAL_HI;
                            else start_clear = 1'b1;
                        end
                        PH_PAL_HI:
                        begin
                            hi_next = in_byte; ph_next = PH_PAL_LO;
                        end
                        PH_PAL_LO:
                        begin
                            cmap_we = 1'b1;
                            cmap_idx = 4'd15 - top_bit;
                            mask_next[top_bit] = 1'b0;
                            if (mask_next != 16'd0) ph_next = PH_PAL_HI;
                            else start_clear = 1'b1;
                        end
                        PH_VCOUNT:
                        begin
                            vtot_next = in_byte; vcnt_next = '0;
                            ph_next = (in_byte == 8'd0) ? PH_POLY : PH_VX;
                        end
                        PH_VX:
                        begin
                            pend_next = in_byte; ph_next = PH_VY;
                        end
                        PH_VY:
                        begin
                            tbl_we = 1'b1;
                            vcnt_next = vcnt_reg + 8'd1;
                            ph_next = (vcnt_next == vtot_reg) ? PH_POLY : PH_VX;
                        end
                        PH_POLY:
                        begin
                            if (in_byte == CODE_END)
                            begin
                                cmd.emit_marker = 1'b1; cmd.marker_kind = KIND_FRAME;
                                cmd.mark_last = 1'b1; ph_next = PH_FLAGS;
                            end
                            else if (in_byte == CODE_SKIP)
                            begin
                                cmd.emit_marker = 1'b1; cmd.marker_kind = KIND_FRAME;
                                cmd.mark_last = 1'b1;
                                ph_next = (pos_next == '0) ? PH_FLAGS : PH_SKIP;
                            end
                            else if (in_byte == CODE_STREAM)
                            begin
                                cmd.emit_marker = 1'b1; cmd.marker_kind = KIND_STREAM;
                                cmd.mark_last = 1'b1; pos_next = '0; ph_next = PH_FLAGS;
                            end
                            else
                            begin
                                pcnt_next = in_byte[3:0]; pcol_next = in_byte[7:4];
                                vcnt_next = '0;
                                if (in_byte[3:0] != 4'd0)
                                    ph_next = flags_reg[2] ? PH_PIDX : PH_PX;
                            end
                        end
                        PH_PIDX:
                        begin
                            fetch_req = 1'b1; seq_next = S_FETCH;
                        end
                        PH_PX:
                        begin
                            pend_next = in_byte; ph_next = PH_PY;
                        end
                        PH_PY:
                        begin
                            ph_next = PH_PX; vert_take = 1'b1;
                        end
                        PH_SKIP:
                        begin
                            if (pos_next == '0) ph_next = PH_FLAGS;
                        end
                        default:
                        begin
                            flags_next = in_byte[2:0];
                            if (in_byte[1])
                            begin
                                ph_next = PH_MASK_HI;
                            end
                            else
                            begin
                                start_clear = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                vx_in = rdx_reg; vy_in = rdy_reg; vert_take = 1'b1;
                seq_next = S_IN;
            end
            S_CLEAR2:
            begin
                if (can_issue)
                begin
                    cmd.emit_clear = 1'b1; cmd.clear_second = 1'b1;
                    cmd.mark_last = 1'b1; seq_next = S_IN;
                end
            end
            S_FAN:
            begin
                if (can_issue)
                begin
                    cmd.emit_fan = 1'b1; cmd.fan_index = fan_reg;
                    cmd.mark_last = (fan_reg == fan_last_reg);
                    fan_next = fan_reg + PvW'(1);
                    if (fan_reg == fan_last_reg) seq_next = S_IN;
                end
            end
            default: seq_next = S_IN;
        endcase

        if (vert_take)
        begin
            vcnt_next = vcnt_reg + 8'd1;
            if (vcnt_next >= {4'd0, pcnt_reg})
            begin
                ph_next = PH_POLY;
                if (fan_cnt >= 4'd3)
                begin
                    fan_next = '0;
                    fan_last_next = PvW'(fan_cnt - 4'd3);
                    seq_next = S_FAN;
                end
                else
                begin
                    seq_next = S_IN;
                end
            end
        end

        // End of the frame header: if flag bit 0 is set, the first clear triangle goes out with this byte.
        if (start_clear)
        begin
            ph_next = flags_next[2] ? PH_VCOUNT : PH_POLY;
            if (flags_next[0])
            begin
                cmd.emit_clear = 1'b1; seq_next = S_CLEAR2;
            end
        end
    end

    assign vert_we     = vert_take & (vcnt_reg < 8'(MaxPolyVerts));
    assign vert_wr_idx = PvW'(vcnt_reg);
    assign vert_x      = vx_in;
    assign vert_y      = vy_in;
    assign fan_color   = cmap_reg[pcol_reg];

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            vxs_mem[tbl_idx] <= pend_reg;
            vys_mem[tbl_idx] <= in_byte;
        end
        if (fetch_req)
        begin
            rdx_reg <= vxs_mem[SlotW'(in_byte)];
            rdy_reg <= vys_mem[SlotW'(in_byte)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= S_IN;   ph_reg <= PH_FLAGS; flags_reg <= '0;
            mask_reg <= '0;    hi_reg <= '0;       vtot_reg <= '0;
            vcnt_reg <= '0;    pcnt_reg <= '0;     pcol_reg <= '0;
            pend_reg <= '0;    pos_reg <= '0;      fan_reg <= '0;
            fan_last_reg <= '0;
            for (int i = 0; i < PaletteSize; i++) cmap_reg[i] <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
            ph_reg <= ph_next;    flags_reg <= flags_next;
            mask_reg <= mask_next; hi_reg <= hi_next; vtot_reg <= vtot_next;
            vcnt_reg <= vcnt_next; pcnt_reg <= pcnt_next; pcol_reg <= pcol_next;
            pend_reg <= pend_next; pos_reg <= pos_next; fan_reg <= fan_next;
            fan_last_reg <= fan_last_next;
            if (cmap_we)
                cmap_reg[cmap_idx] <= pack_rgb({hi_reg, in_byte});
        end
    end
endmodule

// ===== sv/polygon_stream_fan_decoder_core.sv =====
// Polygon stream fan decoder: one byte in, zero to thirteen results out.
// Output: a marker or the first clear triangle is on the output right after the edge that
// accepts its byte; a fan's triangles are issued from S_FAN, entered after its last vertex (via S_FETCH if indexed).
// Input: one byte per cycle while the output is not stalled; an indexed vertex adds the S_FETCH
// table read, a clear its S_CLEAR2 state, and a fan holds the input until its last triangle is issued.
// Reset (rst_n low, asynchronous): parser expects frame flags, color map cleared.
module polygon_stream_fan_decoder_core
    import psfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // stream_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // kind[1:0]
    // ax[8:0], ay[17:9], bx[26:18], by[35:27], cx[44:36], cy[53:45], color[61:54],
    // zero fill[63:62]
    output logic [63:0] m_tdata,
    output logic        m_tlast    // last result of the beat's byte
);
    dp_cmd_t        cmd;
    dp_stat_t       stat;
    logic [PvW-1:0] vidx;
    logic           vwe;
    logic [7:0]     vx, vy, fcol;
    result_t        res;

    // The controller parses bytes and sequences fans; the datapath holds the
    // polygon vertices and the output register.
    psfd_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
        .stat, .cmd(cmd), .vert_wr_idx(vidx), .vert_we(vwe),
        .vert_x(vx), .vert_y(vy), .fan_color(fcol)
    );

    psfd_datapath u_dp (
        .clk, .rst_n, .cmd(cmd), .vert_wr_idx(vidx), .vert_we(vwe),
        .vert_x(vx), .vert_y(vy), .fan_color(fcol), .stat,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {2'b00, res.color, res.cy, res.cx, res.by, res.bx, res.ay, res.ax};
    assign m_tlast = res.last;
endmodule

// ===== sv/psfd_checker.sv =====
// Port-level checker for the polygon stream fan decoder, bound to the top level.
// Depends on psfd_pkg and the assertion macro header.
`include "polygon_stream_fan_decoder_core_assert.svh"
module psfd_checker
    import psfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);
    `PSFD_ASSERT_IMP(a_kind_range, m_tvalid, m_tuser <= KIND_STREAM)
    `PSFD_ASSERT_IMP(a_marker_last, m_tvalid && m_tuser != KIND_TRI, m_tlast)
    `PSFD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tlast, m_tdata}))
    `PSFD_ASSERT_IMP(a_in_gate, s_tready, !m_tvalid || m_tready)
endmodule

bind polygon_stream_fan_decoder_core psfd_checker u_chk (.*);
